/* hw/rtl/wkb_to_fgf_geometry_converter_assert.svh */
// Assertion macros shared by the converter RTL.
// Included inside module bodies; needs signals named clock and reset in scope.
`ifndef WKB_TO_FGF_GEOMETRY_CONVERTER_ASSERT_SVH
`define WKB_TO_FGF_GEOMETRY_CONVERTER_ASSERT_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define WKB_FGF_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define WKB_FGF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/wkb_fgf_pkg.sv */
// Shared types and constants for the WKB to FGF converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wkb_fgf_pkg;

   // Parse phases of the byte stream
   typedef enum logic [2:0] {
      PH_ORDER  = 3'd0,
      PH_TYPE   = 3'd1,
      PH_NPARTS = 3'd2,
      PH_PORDER = 3'd3,
      PH_PTYPE  = 3'd4,
      PH_NCONT  = 3'd5,
      PH_NPTS   = 3'd6,
      PH_COORD  = 3'd7
   } phase_type;

   // Geometry type codes
   localparam logic [30:0] GT_POINT        = 31'd1;
   localparam logic [30:0] GT_POLYGON      = 31'd3;
   localparam logic [30:0] GT_MULTIPOINT   = 31'd4;
   localparam logic [30:0] GT_MULTIPOLYGON = 31'd6;

   localparam logic [31:0] TYPE_MASK = 32'h7FFF_FFFF;

   localparam int OUTQ_DEPTH_DEF = 4;

   typedef struct packed {
      logic [63:0] word;
      logic        is_double;
      logic        last;
   } rsp_entry_type;

   // Up to two result words per input beat
   typedef struct packed {
      logic [1:0]    n;
      rsp_entry_type e0;
      rsp_entry_type e1;
   } parse_out_type;

   typedef struct packed {
      phase_type   phase;
      logic [30:0] cont;
      logic [32:0] coords;
      logic [30:0] parts;
      logic        done;
   } settle_type;

endpackage

`default_nettype wire

/* hw/rtl/wkb_fgf_parser.sv */
// Byte-stream parser: phase, accumulator and counters; decodes up to two words per beat.
// Depends on wkb_fgf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wkb_fgf_parser
   import wkb_fgf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [7:0]    in_byte,
   output parse_out_type      pout
);

   phase_type   phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic [2:0]  pos_ff, pos_in;
   logic [30:0] type_ff, type_in;
   logic        hz_ff, hz_in;
   logic [30:0] parts_ff, parts_in;
   logic [30:0] cont_ff, cont_in;
   logic [32:0] coords_ff, coords_in;

   logic [63:0] word;
   logic        word_done;
   logic [30:0] new_type;
   logic [30:0] cnt;

   function automatic logic needs_pt_count(input logic [30:0] t);
      return (t != GT_POINT) && (t != GT_MULTIPOINT);
   endfunction

   // Next phase once a word is finished; done marks the end of the geometry.
   function automatic settle_type settle(input logic [32:0] coords,
                                         input logic [30:0] cont,
                                         input logic [30:0] parts,
                                         input logic [30:0] t,
                                         input logic        hz);
      settle_type s;
      s = '{phase: PH_ORDER, cont: cont, coords: coords, parts: parts, done: 1'b0};
      priority if (coords != '0) begin
         s.phase = PH_COORD;
      end else if (cont != '0) begin
         s.cont = cont - 31'd1;
         if (needs_pt_count(t)) begin
            s.phase = PH_NPTS;
         end else begin
            s.coords = hz ? 33'd3 : 33'd2;
            s.phase  = PH_COORD;
         end
      end else if (parts != '0) begin
         s.parts = parts - 31'd1;
         s.phase = PH_PORDER;
      end else begin
         s.phase = PH_ORDER;
         s.done  = 1'b1;
      end
      return s;
   endfunction

   assign word      = acc_ff | ({56'd0, in_byte} << {pos_ff, 3'b000});
   assign word_done = (pos_ff == ((phase_ff == PH_COORD) ? 3'd7 : 3'd3));
   assign new_type  = word[30:0];
   // negative count reads as zero
   assign cnt       = word[31] ? 31'd0 : word[30:0];

   always_comb begin
      settle_type st;
      logic       do_settle;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      pos_in    = pos_ff;
      type_in   = type_ff;
      hz_in     = hz_ff;
      parts_in  = parts_ff;
      cont_in   = cont_ff;
      coords_in = coords_ff;
      pout      = '0;
      do_settle = 1'b0;
      st        = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_ORDER: begin
               phase_in = PH_TYPE;
               acc_in   = '0;
               pos_in   = '0;
            end
            PH_PORDER: begin
               phase_in = PH_PTYPE;
               acc_in   = '0;
               pos_in   = '0;
            end
            default: begin
               if (!word_done) begin
                  acc_in = word;
                  pos_in = pos_ff + 3'd1;
               end else begin
                  acc_in = '0;
                  pos_in = '0;
                  unique case (phase_ff)
                     PH_TYPE, PH_PTYPE: begin
                        type_in = new_type;
                        hz_in   = word[31];
                        pout.e0 = '{word: {33'd0, new_type}, is_double: 1'b0, last: 1'b0};
                        if (phase_ff == PH_TYPE) begin
                           parts_in  = '0;
                           cont_in   = '0;
                           coords_in = '0;
                        end
                        if (phase_ff == PH_TYPE && new_type >= GT_MULTIPOINT
                            && new_type <= GT_MULTIPOLYGON) begin
                           phase_in = PH_NPARTS;
                           pout.n   = 2'd1;
                        end else begin
                           pout.n    = 2'd2;
                           pout.e1   = '{word: {63'd0, word[31]}, is_double: 1'b0,
                                         last: 1'b0};
                           coords_in = '0;
                           if (new_type == GT_POLYGON || new_type == GT_MULTIPOLYGON) begin
                              phase_in = PH_NCONT;
                           end else begin
                              cont_in   = 31'd1;
                              do_settle = 1'b1;
                           end
                        end
                     end
                     PH_NPARTS: begin
                        parts_in  = cnt;
                        cont_in   = '0;
                        coords_in = '0;
                        do_settle = 1'b1;
                        pout.n    = 2'd1;
                        pout.e0   = '{word: word, is_double: 1'b0, last: 1'b0};
                     end
                     PH_NCONT: begin
                        cont_in   = cnt;
                        coords_in = '0;
                        do_settle = 1'b1;
                        pout.n    = 2'd1;
                        pout.e0   = '{word: word, is_double: 1'b0, last: 1'b0};
                     end
                     PH_NPTS: begin
                        // points times 2 or 3 doubles
                        coords_in = hz_ff ? ({2'b00, cnt} + {1'b0, cnt, 1'b0})
                                          : {1'b0, cnt, 1'b0};
                        do_settle = 1'b1;
                        pout.n    = 2'd1;
                        pout.e0   = '{word: word, is_double: 1'b0, last: 1'b0};
                     end
                     default: begin
                        if (coords_ff != '0) begin
                           coords_in = coords_ff - 33'd1;
                        end
                        do_settle = 1'b1;
                        pout.n    = 2'd1;
                        pout.e0   = '{word: word, is_double: 1'b1, last: 1'b0};
                     end
                  endcase
                  if (do_settle) begin
                     st           = settle(coords_in, cont_in, parts_in, type_in, hz_in);
                     phase_in     = st.phase;
                     cont_in      = st.cont;
                     coords_in    = st.coords;
                     parts_in     = st.parts;
                     pout.e0.last = st.done;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_ORDER;
         acc_ff    <= '0;
         pos_ff    <= '0;
         type_ff   <= '0;
         hz_ff     <= 1'b0;
         parts_ff  <= '0;
         cont_ff   <= '0;
         coords_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         pos_ff    <= pos_in;
         type_ff   <= type_in;
         hz_ff     <= hz_in;
         parts_ff  <= parts_in;
         cont_ff   <= cont_in;
         coords_ff <= coords_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/wkb_fgf_outq.sv */
// Result queue: takes up to two words a cycle, hands out one; acts as the result register.
// Depends on wkb_fgf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wkb_fgf_outq
   import wkb_fgf_pkg::*;
#(
   parameter int Depth = OUTQ_DEPTH_DEF,
   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1,
   localparam int CntW = $clog2(Depth + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire parse_out_type push,
   input  wire logic          pop,
   output rsp_entry_type      head,
   output logic               not_empty,
   output logic               has_room,
   output logic [CntW-1:0]    count
);

   rsp_entry_type         mem_ff [Depth];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr1;
   logic [CntW-1:0]       count_ff, count_in;

   function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   assign wr_ptr1   = inc(wr_ptr_ff);
   assign wr_ptr_in = (push.n == 2'd0) ? wr_ptr_ff :
                      (push.n == 2'd1) ? wr_ptr1 : inc(wr_ptr1);
   assign rd_ptr_in = pop ? inc(rd_ptr_ff) : rd_ptr_ff;
   assign count_in  = count_ff + CntW'(push.n) - CntW'(pop);

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   // room for a two-word beat
   assign has_room  = (count_ff <= CntW'(Depth - 2));
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.e0;
      end
      if (push.n == 2'd2) begin
         mem_ff[wr_ptr1] <= push.e1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/wkb_to_fgf_geometry_converter.sv */
// Top level of the WKB to FGF geometry converter: parser plus result queue.
// Depends on wkb_fgf_pkg, wkb_fgf_parser, wkb_fgf_outq and the assertion header.
//
//   channel | ports                                   | beat
//   --------+-----------------------------------------+------------------------------
//   req     | req_valid/req_ready, req_in_byte        | one WKB byte
//   rsp     | rsp_valid/rsp_ready, rsp_out_word,      | one FGF word (int or double)
//           | rsp_out_is_double, rsp_out_last         |
//
// One byte a cycle is accepted while req_ready is high; each byte is decoded in the cycle it is taken.
// A beat yields zero, one or two words; words leave one a cycle while rsp_ready is high, so
// the rsp port sets the sustained rate (type bytes that add a dimension word push two words).
// req_ready drops while the queue cannot take two more words (more than Depth-2 held).
// Synchronous reset returns the parser to waiting for a byte-order byte and empties
// the queue; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module wkb_to_fgf_geometry_converter
   import wkb_fgf_pkg::*;
#(
   parameter int OutqDepth = OUTQ_DEPTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [7:0]    req_in_byte,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [63:0]        rsp_out_word,
   output logic               rsp_out_is_double,
   output logic               rsp_out_last
);

   localparam int CntW = $clog2(OutqDepth + 1);

   logic            req_acc;
   logic            rsp_acc;
   parse_out_type   pout;
   rsp_entry_type   head;
   logic [CntW-1:0] q_count;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // decode: state and accumulator update on each accepted byte
   wkb_fgf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_acc),
      .in_byte (req_in_byte),
      .pout    (pout)
   );

   // decoded words are registered here and drained one per beat
   wkb_fgf_outq #(
      .Depth (OutqDepth)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (pout),
      .pop       (rsp_acc),
      .head      (head),
      .not_empty (rsp_valid),
      .has_room  (req_ready),
      .count     (q_count)
   );

   assign rsp_out_word      = head.word;
   assign rsp_out_is_double = head.is_double;
   assign rsp_out_last      = head.last;

`include "wkb_to_fgf_geometry_converter_assert.svh"

   `WKB_FGF_ASSERT_IMPL(a_push_fits, req_acc, q_count <= CntW'(OutqDepth - 2), "queue overrun on accept")
   `WKB_FGF_ASSERT_IMPL(a_no_push_idle, !req_acc, pout.n == 2'd0, "words produced without a beat")
   `WKB_FGF_ASSERT_IMPL(a_dim_word, pout.n == 2'd2, !pout.e1.last && !pout.e1.is_double, "bad dimension word")
   `WKB_FGF_ASSERT_NEXT(a_two_words, pout.n == 2'd2 && !rsp_acc, q_count == $past(q_count) + CntW'(2), "two-word beat lost")

endmodule

`default_nettype wire
